// ===== hdl/wadt_pkg.sv =====
package wadt_pkg;

    // Field widths of the alert and result words.
    localparam int ADDR_W     = 32;
    localparam int KIND_W     = 4;
    localparam int SEV_W      = 2;
    localparam int TIME_W     = 32;
    localparam int VERDICT_W  = 2;
    localparam int REPEAT_W   = 24;
    localparam int KEY_W      = ADDR_W + KIND_W;

    // Configuration register widths.
    localparam int WINDOW_W   = 16;
    localparam int STALE_W    = 17;
    localparam int PERIOD_W   = 11;

    // APB register map.
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 2;
    localparam logic [REG_IDX_W-1:0] REG_WINDOW = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STALE  = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PERIOD = 2'd2;

    // Register reset values.
    localparam logic [WINDOW_W-1:0] WINDOW_RST = 16'd60;
    localparam logic [STALE_W-1:0]  STALE_RST  = 17'd120;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 11'd10;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] VERDICT_NEW       = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_SUPPRESS  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_AGGREGATE = 2'd2;

    // Set hash constants.
    localparam logic [31:0] HASH_MULT  = 32'h9E37_79B1;
    localparam int          KIND_SHIFT = 28;
    localparam int          HASH_FOLD  = 15;

    typedef struct packed {
        logic [ADDR_W-1:0] source_address;
        logic [KIND_W-1:0] alert_kind;
        logic [SEV_W-1:0]  severity;
        logic [TIME_W-1:0] now_seconds;
    } t_alert;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [REPEAT_W-1:0]  repeat_count;
        logic [SEV_W-1:0]     peak_severity;
        logic                 not_stored;
    } t_result;

    typedef struct packed {
        logic [WINDOW_W-1:0] window_seconds;
        logic [STALE_W-1:0]  stale_seconds;
        logic [PERIOD_W-1:0] aggregate_period;
    } t_cfg;

endpackage

// ===== hdl/wadt_if.sv =====
interface wadt_alert_if;
    import wadt_pkg::*;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] source_address;
    logic [KIND_W-1:0] alert_kind;
    logic [SEV_W-1:0]  severity;
    logic [TIME_W-1:0] now_seconds;

    modport source (output valid, source_address, alert_kind, severity, now_seconds,
                    input ready);
    modport sink (input valid, source_address, alert_kind, severity, now_seconds,
                  output ready);
endinterface

interface wadt_result_if;
    import wadt_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [REPEAT_W-1:0]  repeat_count;
    logic [SEV_W-1:0]     peak_severity;
    logic                 not_stored;

    modport source (output valid, verdict, repeat_count, peak_severity, not_stored,
                    input ready);
    modport sink (input valid, verdict, repeat_count, peak_severity, not_stored,
                  output ready);
endinterface

// ===== hdl/wadt_ram.sv =====
module wadt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/wadt_fifo.sv =====
module wadt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

// ===== hdl/wadt_front.sv =====
module wadt_front #(
    parameter int NUM_SETS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  wadt_pkg::t_alert      i_alert,
    output logic                  o_valid,
    input  logic                  i_ready,
    output wadt_pkg::t_alert      o_alert,
    output logic [((NUM_SETS > 1) ? $clog2(NUM_SETS) : 1)-1:0] o_set
);
    import wadt_pkg::*;

    localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int RECIP_SH = 32 + $clog2(NUM_SETS);
    localparam logic [32:0] RECIP  = 33'((64'd1 << RECIP_SH) / 64'(NUM_SETS));
    localparam logic [31:0] SETS_C = 32'(NUM_SETS);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_QUO  = 2'd1;
    localparam logic [1:0] F_REM  = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]       r_state, n_state;
    t_alert           r_alert;
    logic [31:0]      r_h;
    logic [31:0]      r_q;
    logic [SET_W-1:0] r_rem;
    logic [31:0]      x_in;
    logic [63:0]      prod;
    logic [31:0]      mixed;
    logic [64:0]      qprod;
    logic [31:0]      qn, diff, rem;

    assign o_ready = (r_state == F_IDLE);
    assign o_valid = (r_state == F_PUSH);
    assign o_alert = r_alert;
    assign o_set   = r_rem;

    // Key mix, hash multiply and fold, taken straight from the incoming word.
    assign x_in  = i_alert.source_address
                 ^ {i_alert.alert_kind, (KIND_SHIFT)'(0)}
                 ^ {(32 - KIND_W)'(0), i_alert.alert_kind};
    assign prod  = 64'(x_in) * 64'(HASH_MULT);
    assign mixed = prod[31:0] ^ (prod[31:0] >> HASH_FOLD);

    // Set index by reciprocal multiplication. The quotient estimate is exact or
    // one too small, so a single conditional subtract finishes the remainder.
    assign qprod = 65'(r_h) * 65'(RECIP);
    assign qn    = r_q * SETS_C;
    assign diff  = r_h - qn;
    assign rem   = (diff >= SETS_C) ? diff - SETS_C : diff;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: if (i_valid) n_state = F_QUO;
            F_QUO:  n_state = F_REM;
            F_REM:  n_state = F_PUSH;
            F_PUSH: if (i_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            F_IDLE: begin
                r_alert <= i_alert;
                r_h     <= mixed;
            end
            F_QUO: begin
                r_q <= 32'(qprod >> RECIP_SH);
            end
            F_REM: begin
                r_rem <= SET_W'(rem);
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== hdl/wadt_back.sv =====
module wadt_back #(
    parameter int NUM_SETS   = 256,
    parameter int NUM_WAYS   = 4,
    parameter int COUNT_BITS = 24
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  wadt_pkg::t_cfg        i_cfg,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  wadt_pkg::t_alert      i_alert,
    input  logic [((NUM_SETS > 1) ? $clog2(NUM_SETS) : 1)-1:0] i_set,
    output logic                  o_valid,
    input  logic                  i_ready,
    output wadt_pkg::t_result     o_result
);
    import wadt_pkg::*;

    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int WAY_W     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int DIV_STEPS = (COUNT_BITS + 3) / 4;
    localparam int DIV_W     = DIV_STEPS * 4;
    localparam int DCNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;
    localparam logic [1:0] S_DIV  = 2'd3;

    typedef struct packed {
        logic                  valid;
        logic [KEY_W-1:0]      key;
        logic [TIME_W-1:0]     first;
        logic [TIME_W-1:0]     last;
        logic [COUNT_BITS-1:0] cnt;
        logic [SEV_W-1:0]      peak;
    } t_way;
    typedef t_way [NUM_WAYS-1:0] t_row;
    localparam int ROW_W = $bits(t_row);

    logic [1:0]            r_state, n_state;
    logic                  r_clr;
    logic [SET_W-1:0]      r_clr_idx;
    t_alert                r_alert;
    logic [SET_W-1:0]      r_set;
    t_row                  r_row;
    logic                  r_hit, r_free, r_stale;
    logic [WAY_W-1:0]      r_hit_way, r_free_way, r_stale_way;
    logic                  r_out_valid;
    t_result               r_out;
    logic [PERIOD_W-1:0]   r_rem, n_rem;
    logic [DIV_W-1:0]      r_dsh;
    logic [DCNT_W-1:0]     r_dcnt;

    t_row                  rd_row, new_row;
    logic [ROW_W-1:0]      ram_rdata, ram_wdata;
    logic                  ram_we;
    logic [SET_W-1:0]      ram_waddr;
    logic [KEY_W-1:0]      key;
    logic                  l_hit, l_free, l_stale;
    logic [WAY_W-1:0]      l_hit_way, l_free_way, l_stale_way;
    logic                  win_open, do_write, do_div;
    logic [WAY_W-1:0]      victim;
    logic [COUNT_BITS-1:0] inc_cnt;
    logic [SEV_W-1:0]      upd_peak;
    t_way                  hit_entry;
    logic [PERIOD_W:0]     v_t;

    assign key       = {r_alert.source_address, r_alert.alert_kind};
    assign rd_row    = t_row'(ram_rdata);
    assign o_ready   = (r_state == S_IDLE) && !r_clr && !r_out_valid;
    assign o_valid   = r_out_valid;
    assign o_result  = r_out;

    // Set row memory: all ways of one set in one word.
    wadt_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (i_set),
        .o_rdata (ram_rdata)
    );

    // Way lookup: first hit, first free way, first stale way.
    always_comb begin
        l_hit = 1'b0;
        l_free = 1'b0;
        l_stale = 1'b0;
        l_hit_way = '0;
        l_free_way = '0;
        l_stale_way = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (rd_row[w].valid) begin
                if (rd_row[w].key == key) begin
                    l_hit = 1'b1;
                    l_hit_way = WAY_W'(w);
                end
                if ((r_alert.now_seconds - rd_row[w].last) >
                    TIME_W'(i_cfg.stale_seconds)) begin
                    l_stale = 1'b1;
                    l_stale_way = WAY_W'(w);
                end
            end else begin
                l_free = 1'b1;
                l_free_way = WAY_W'(w);
            end
        end
    end

    // Update of the chosen way.
    always_comb begin
        hit_entry = r_row[r_hit_way];
        win_open  = (r_alert.now_seconds - hit_entry.first) <=
                    TIME_W'(i_cfg.window_seconds);
        inc_cnt   = (hit_entry.cnt == COUNT_MAX) ? hit_entry.cnt : hit_entry.cnt + 1'b1;
        upd_peak  = (r_alert.severity > hit_entry.peak) ? r_alert.severity : hit_entry.peak;
        new_row   = r_row;
        do_write  = 1'b1;
        do_div    = 1'b0;
        victim    = r_hit ? r_hit_way : (r_free ? r_free_way : r_stale_way);
        if (r_hit && win_open) begin
            new_row[victim].cnt  = inc_cnt;
            new_row[victim].last = r_alert.now_seconds;
            new_row[victim].peak = upd_peak;
            do_div = (i_cfg.aggregate_period != '0);
        end else if (r_hit || r_free || r_stale) begin
            new_row[victim].valid = 1'b1;
            new_row[victim].key   = key;
            new_row[victim].first = r_alert.now_seconds;
            new_row[victim].last  = r_alert.now_seconds;
            new_row[victim].cnt   = COUNT_BITS'(1);
            new_row[victim].peak  = r_alert.severity;
        end else begin
            do_write = 1'b0;
        end
    end

    // Memory write: clearing pass after reset, else writeback.
    assign ram_we    = r_clr || ((r_state == S_UPD) && do_write);
    assign ram_waddr = r_clr ? r_clr_idx : r_set;
    assign ram_wdata = r_clr ? '0 : ROW_W'(new_row);

    // Remainder by the period, four count bits per cycle.
    always_comb begin
        n_rem = r_rem;
        for (int b = 3; b >= 0; b--) begin
            v_t = {n_rem, r_dsh[DIV_W - 4 + b]};
            if (v_t >= {1'b0, i_cfg.aggregate_period}) begin
                v_t = v_t - {1'b0, i_cfg.aggregate_period};
            end
            n_rem = v_t[PERIOD_W-1:0];
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid && o_ready) n_state = S_LOOK;
            S_LOOK: n_state = S_UPD;
            S_UPD:  n_state = do_div ? S_DIV : S_IDLE;
            S_DIV:  if (r_dcnt == DCNT_W'(DIV_STEPS - 1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_clr       <= 1'b1;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_clr) begin
                if (r_clr_idx == SET_W'(NUM_SETS - 1)) begin
                    r_clr <= 1'b0;
                end else begin
                    r_clr_idx <= r_clr_idx + 1'b1;
                end
            end
            if ((r_state == S_UPD && !do_div) ||
                (r_state == S_DIV && r_dcnt == DCNT_W'(DIV_STEPS - 1))) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_alert <= i_alert;
                r_set   <= i_set;
            end
            S_LOOK: begin
                r_row       <= rd_row;
                r_hit       <= l_hit;
                r_free      <= l_free;
                r_stale     <= l_stale;
                r_hit_way   <= l_hit_way;
                r_free_way  <= l_free_way;
                r_stale_way <= l_stale_way;
            end
            S_UPD: begin
                r_rem  <= '0;
                r_dcnt <= '0;
                r_dsh  <= DIV_W'(inc_cnt);
                if (r_hit && win_open) begin
                    r_out.verdict       <= VERDICT_SUPPRESS;
                    r_out.repeat_count  <= REPEAT_W'(inc_cnt);
                    r_out.peak_severity <= upd_peak;
                    r_out.not_stored    <= 1'b0;
                end else begin
                    r_out.verdict       <= VERDICT_NEW;
                    r_out.repeat_count  <= REPEAT_W'(1);
                    r_out.peak_severity <= r_alert.severity;
                    r_out.not_stored    <= !do_write;
                end
            end
            S_DIV: begin
                r_rem  <= n_rem;
                r_dsh  <= r_dsh << 4;
                r_dcnt <= r_dcnt + 1'b1;
                if (r_dcnt == DCNT_W'(DIV_STEPS - 1) && n_rem == '0) begin
                    r_out.verdict <= VERDICT_AGGREGATE;
                end
            end
            default: begin
            end
        endcase
    end
endmodule

// ===== hdl/windowed_alert_dedup_table_unit.sv =====
// Alert deduplication table. Each alert word is hashed on (address, kind) to one of
// NUM_SETS sets of NUM_WAYS ways; a repeat inside the window is suppressed or, every
// aggregate_period repeats, aggregated; anything else opens a new window unless no way
// matches and none is free or stale. The front end steps through hash multiply on
// accept, set-index quotient estimate, remainder correction and queue push for each
// alert and hands it through a two-word queue to the table engine, which reads its
// set-row memory, looks up, writes back and returns a result, plus a period remainder
// on an in-window repeat with a nonzero period; neither side overlaps alerts. After
// reset the table is cleared before the first lookup; configuration writes are taken
// throughout. Write the registers only while no alert is in flight.
module windowed_alert_dedup_table_unit #(
    parameter int NUM_SETS   = 256,
    parameter int NUM_WAYS   = 4,
    parameter int COUNT_BITS = 24
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    wadt_alert_if.sink                   i_alert,
    wadt_result_if.source                o_result,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [wadt_pkg::PADDR_W-1:0] paddr,
    input  logic [wadt_pkg::PDATA_W-1:0] pwdata,
    output logic [wadt_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import wadt_pkg::*;

    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int JOB_W  = $bits(t_alert) + SET_W;

    t_cfg             r_cfg;
    t_alert           in_alert, f_alert, b_alert;
    logic [SET_W-1:0] f_set, b_set;
    logic             f_valid, f_ready, q_valid, q_ready;
    t_result          b_result;
    logic [REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[PADDR_W-1:2];
    assign pready  = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.window_seconds   <= WINDOW_RST;
            r_cfg.stale_seconds    <= STALE_RST;
            r_cfg.aggregate_period <= PERIOD_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_WINDOW: r_cfg.window_seconds   <= pwdata[WINDOW_W-1:0];
                REG_STALE:  r_cfg.stale_seconds    <= pwdata[STALE_W-1:0];
                REG_PERIOD: r_cfg.aggregate_period <= pwdata[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (reg_idx)
            REG_WINDOW: prdata = PDATA_W'(r_cfg.window_seconds);
            REG_STALE:  prdata = PDATA_W'(r_cfg.stale_seconds);
            REG_PERIOD: prdata = PDATA_W'(r_cfg.aggregate_period);
            default:    prdata = '0;
        endcase
    end

    assign in_alert.source_address = i_alert.source_address;
    assign in_alert.alert_kind     = i_alert.alert_kind;
    assign in_alert.severity       = i_alert.severity;
    assign in_alert.now_seconds    = i_alert.now_seconds;

    // Hash front end.
    wadt_front #(.NUM_SETS(NUM_SETS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_alert.valid),
        .o_ready (i_alert.ready),
        .i_alert (in_alert),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_alert (f_alert),
        .o_set   (f_set)
    );

    // Queue between hashing and table engine.
    wadt_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_alert, f_set}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  ({b_alert, b_set})
    );

    // Table engine.
    wadt_back #(
        .NUM_SETS   (NUM_SETS),
        .NUM_WAYS   (NUM_WAYS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (q_valid),
        .o_ready  (q_ready),
        .i_alert  (b_alert),
        .i_set    (b_set),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (b_result)
    );

    assign o_result.verdict       = b_result.verdict;
    assign o_result.repeat_count  = b_result.repeat_count;
    assign o_result.peak_severity = b_result.peak_severity;
    assign o_result.not_stored    = b_result.not_stored;
endmodule

// ===== hdl/wadt_checker.sv =====
module wadt_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_valid,
    input logic                             i_ready,
    input logic [wadt_pkg::VERDICT_W-1:0]   i_verdict,
    input logic [wadt_pkg::REPEAT_W-1:0]    i_repeat_count,
    input logic                             i_not_stored
);
    import wadt_pkg::*;

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_verdict) && $stable(i_repeat_count))
        else $error("result word changed while stalled");

    // Only defined verdicts appear.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_verdict == VERDICT_NEW || i_verdict == VERDICT_SUPPRESS ||
                     i_verdict == VERDICT_AGGREGATE))
        else $error("undefined verdict");

    // A new window always starts at a count of one.
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_verdict == VERDICT_NEW |-> i_repeat_count == REPEAT_W'(1))
        else $error("new alert with count other than one");

    // A full set only ever answers new.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_not_stored |-> i_verdict == VERDICT_NEW)
        else $error("unstored alert not reported as new");

    // Repeats come from a stored entry.
    a_rep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_verdict != VERDICT_NEW |-> !i_not_stored)
        else $error("repeat flagged as not stored");
endmodule

bind windowed_alert_dedup_table_unit wadt_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_result.valid),
    .i_ready        (o_result.ready),
    .i_verdict      (o_result.verdict),
    .i_repeat_count (o_result.repeat_count),
    .i_not_stored   (o_result.not_stored)
);

// ===== tb/sv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wadt_pkg::*;

    localparam int SETS      = 256;
    localparam int WAYS      = 4;
    localparam int CNT_MAX   = (1 << 24) - 1;
    localparam int CYCLE_CAP = 1500000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    wadt_alert_if  alert_bus ();
    wadt_result_if result_bus ();

    windowed_alert_dedup_table_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_alert (alert_bus.sink),
        .o_result(result_bus.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 i_clk = ~i_clk;

    // Shadow copy of the table and registers.
    logic [WINDOW_W-1:0] win_sec;
    logic [STALE_W-1:0]  stale_sec;
    logic [PERIOD_W-1:0] agg_period;
    bit          slot_valid [SETS*WAYS];
    logic [35:0] slot_key   [SETS*WAYS];
    logic [31:0] slot_first [SETS*WAYS];
    logic [31:0] slot_last  [SETS*WAYS];
    logic [23:0] slot_count [SETS*WAYS];
    logic [1:0]  slot_peak  [SETS*WAYS];

    t_result pending_verdicts[$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;
    logic [31:0] clock_now = 32'd1000;

    initial begin
        alert_bus.valid = 1'b0;
        alert_bus.source_address = '0;
        alert_bus.alert_kind = '0;
        alert_bus.severity = '0;
        alert_bus.now_seconds = '0;
        result_bus.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int set_index(logic [31:0] addr, logic [3:0] kind);
        logic [31:0] x;
        x = addr ^ ({28'd0, kind} << 28) ^ {28'd0, kind};
        x = x * 32'h9E3779B1;
        x = x ^ (x >> 15);
        return int'(x % SETS);
    endfunction

    // Predict the verdict for one alert and update the shadow table.
    function automatic t_result dedup_predict(t_alert a);
        t_result r;
        int base, hit, free_w, stale_w, s;
        logic [35:0] key;
        key = {a.source_address, a.alert_kind};
        base = set_index(a.source_address, a.alert_kind) * WAYS;
        hit = -1; free_w = -1; stale_w = -1;
        r.verdict = VERDICT_NEW;
        r.repeat_count = 24'd1;
        r.peak_severity = a.severity;
        r.not_stored = 1'b0;
        for (int w = 0; w < WAYS; w++) begin
            s = base + w;
            if (slot_valid[s]) begin
                if (slot_key[s] == key && hit < 0) hit = w;
                if (stale_w < 0 && (a.now_seconds - slot_last[s]) > {15'd0, stale_sec})
                    stale_w = w;
            end else if (free_w < 0) begin
                free_w = w;
            end
        end
        if (hit >= 0 && (a.now_seconds - slot_first[base+hit]) <= {16'd0, win_sec}) begin
            s = base + hit;
            if (slot_count[s] < CNT_MAX) slot_count[s] = slot_count[s] + 1;
            slot_last[s] = a.now_seconds;
            if (a.severity > slot_peak[s]) slot_peak[s] = a.severity;
            r.repeat_count = slot_count[s];
            r.peak_severity = slot_peak[s];
            if (agg_period != 0 && (slot_count[s] % agg_period) == 0)
                r.verdict = VERDICT_AGGREGATE;
            else
                r.verdict = VERDICT_SUPPRESS;
            return r;
        end
        if (hit >= 0) s = base + hit;
        else if (free_w >= 0) s = base + free_w;
        else if (stale_w >= 0) s = base + stale_w;
        else begin
            r.not_stored = 1'b1;
            return r;
        end
        slot_valid[s] = 1'b1;
        slot_key[s] = key;
        slot_first[s] = a.now_seconds;
        slot_last[s] = a.now_seconds;
        slot_count[s] = 24'd1;
        slot_peak[s] = a.severity;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // Result side: random stalls, compare against the oldest expected word.
    always @(posedge i_clk) begin
        t_result want;
        if (result_bus.valid && result_bus.ready) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                want = pending_verdicts.pop_front();
                if (result_bus.verdict !== want.verdict)
                    report_mismatch("verdict", result_bus.verdict, want.verdict);
                if (result_bus.repeat_count !== want.repeat_count)
                    report_mismatch("repeat_count", result_bus.repeat_count,
                                    want.repeat_count);
                if (result_bus.peak_severity !== want.peak_severity)
                    report_mismatch("peak_severity", result_bus.peak_severity,
                                    want.peak_severity);
                if (result_bus.not_stored !== want.not_stored)
                    report_mismatch("not_stored", result_bus.not_stored, want.not_stored);
            end
        end
        if (!i_rst_n) result_bus.ready <= 1'b0;
        else result_bus.ready <= no_idle || ($urandom_range(99) >= 26);
    end

    // Send one alert word, with a random gap before it. Valid stays high after the
    // accepting edge until the next word or an idle cycle replaces it.
    task automatic send_alert(logic [31:0] addr, logic [3:0] kind, logic [1:0] sev,
                              logic [31:0] now_s);
        t_alert a;
        a = {addr, kind, sev, now_s};
        if (!no_idle) begin
            while ($urandom_range(99) < 26) begin
                alert_bus.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        alert_bus.valid <= 1'b1;
        alert_bus.source_address <= addr;
        alert_bus.alert_kind <= kind;
        alert_bus.severity <= sev;
        alert_bus.now_seconds <= now_s;
        do @(posedge i_clk); while (!alert_bus.ready);
        pending_verdicts.push_back(dedup_predict(a));
    endtask

    task automatic drain_results();
        alert_bus.valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // One APB write; the bus is left selected so writes can follow back to back.
    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= PADDR_W'(idx) << 2; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_WINDOW: win_sec = value[WINDOW_W-1:0];
            REG_STALE:  stale_sec = value[STALE_W-1:0];
            REG_PERIOD: agg_period = value[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int w, int st, int p);
        drain_results();
        write_reg(REG_WINDOW, w);
        write_reg(REG_STALE, st);
        write_reg(REG_PERIOD, p);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Field extremes, window edges, period hits and full-set overflow.
    task automatic test_directed();
        logic [31:0] a;
        send_alert(32'h0, 4'h0, 2'd0, 32'h0);
        send_alert(32'hFFFF_FFFF, 4'hF, 2'd3, 32'hFFFF_FFFF);
        send_alert(32'h0, 4'h0, 2'd2, 32'd60);
        send_alert(32'h0, 4'h0, 2'd1, 32'd61);
        send_alert(32'hFFFF_FFFF, 4'hF, 2'd0, 32'd59);
        a = 32'hC0A8_0001;
        for (int i = 0; i < 10; i++) send_alert(a, 4'h5, 2'(i), 32'd5000 + i);
        // Fill one set with five keys of the same index.
        begin
            int target, found;
            target = set_index(32'h1234_0000, 4'h3);
            found = 0;
            for (int k = 0; found < 5 && k < 100000; k++) begin
                if (set_index(32'h1234_0000 + k, 4'h3) == target) begin
                    send_alert(32'h1234_0000 + k, 4'h3, 2'(k), 32'd9000);
                    found++;
                end
            end
            send_alert(32'h1234_0000, 4'h3, 2'd1, 32'd9500);
        end
    endtask

    // Mostly repeats of a small key pool with a slowly moving clock.
    task automatic test_random(int n, int pool);
        logic [31:0] addr;
        logic [3:0]  kind;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) < 8) begin
                addr = 32'h0A00_0000 + $urandom_range(pool - 1);
                kind = 4'($urandom_range(1));
            end else begin
                addr = $urandom;
                kind = 4'($urandom);
            end
            if ($urandom_range(9) == 0) clock_now = clock_now + $urandom_range(200);
            else clock_now = clock_now + $urandom_range(2);
            send_alert(addr, kind, 2'($urandom), clock_now);
        end
    endtask

    // Time wraparound on repeat differences.
    task automatic test_wrap();
        send_alert(32'hDEAD_BEEF, 4'hA, 2'd1, 32'hFFFF_FFF0);
        send_alert(32'hDEAD_BEEF, 4'hA, 2'd2, 32'h0000_0010);
        clock_now = 32'hFFFF_FF00;
        test_random(150, 12);
    endtask

    initial begin
        win_sec = WINDOW_RST;
        stale_sec = STALE_RST;
        agg_period = PERIOD_RST;
        for (int i = 0; i < SETS * WAYS; i++) slot_valid[i] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random(400, 24);
        set_config(1, 1, 1);
        test_random(200, 8);
        set_config(65535, 131070, 0);
        test_random(200, 16);
        no_idle = 1'b1;
        set_config(65535, 131071, 2047);
        test_random(200, 16);
        no_idle = 1'b0;
        set_config(5, 3, 1024);
        test_wrap();
        set_config(60, 120, 3);
        test_random(480, 40);

        drain_results();
        if (mismatches == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end
endmodule
